[src/rtbk_pkg.sv]
// package for the running top/bottom-k tracker
// widths, defaults, request kinds and the cell control struct
// no dependencies
package rtbk_pkg;

  localparam int unsigned DEF_MAX_KEPT   = 64;
  localparam int unsigned DEF_VALUE_BITS = 32;
  localparam int unsigned OUT_BITS       = 32;
  localparam int unsigned COUNT_BITS     = 7;
  localparam int unsigned INDEX_BITS     = 6;
  localparam int unsigned INDEX_SPAN     = 64;
  localparam logic [COUNT_BITS-1:0] KEPT_RESET = 7'd64;

  typedef enum logic {
    REQ_OFFER = 1'b0,
    REQ_READ  = 1'b1
  } req_kind_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic offer;
    logic up_taken;
    logic lo_taken;
  } cell_ctl_t;

endpackage

[src/rtbk_if.sv]
// channel interfaces of the running top/bottom-k tracker
// request, result and configuration write channels; uses rtbk_pkg
interface rtbk_req_if import rtbk_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [OUT_BITS-1:0]   value;
  logic [INDEX_BITS-1:0]        index;

  modport source (output valid, req_type, value, index, input ready);
  modport sink (input valid, req_type, value, index, output ready);
endinterface

interface rtbk_res_if import rtbk_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [OUT_BITS-1:0]   upper_entry;
  logic signed [OUT_BITS-1:0]   lower_entry;
  logic                         upper_taken;
  logic                         lower_taken;
  logic signed [OUT_BITS-1:0]   upper_floor;
  logic signed [OUT_BITS-1:0]   lower_ceiling;

  modport source (output valid, upper_entry, lower_entry, upper_taken, lower_taken,
                  upper_floor, lower_ceiling, input ready);
  modport sink (input valid, upper_entry, lower_entry, upper_taken, lower_taken,
                upper_floor, lower_ceiling, output ready);
endinterface

interface rtbk_cfg_if import rtbk_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[src/rtbk_cell.sv]
// one position of both sorted lists: holds upper and lower entry
// compares against the offered value and shifts from its neighbors; uses rtbk_pkg
module rtbk_cell import rtbk_pkg::*; #(
  parameter int unsigned POS        = 0,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS,
  parameter int unsigned NW         = COUNT_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cell_ctl_t                    ctl,
  input  logic signed [VALUE_BITS-1:0] v,
  input  logic [NW-1:0]                used_n,
  input  logic [INDEX_BITS-1:0]        rd_index,
  input  logic signed [VALUE_BITS-1:0] up_nb,
  input  logic signed [VALUE_BITS-1:0] lo_nb,
  input  logic                         up_above_in,
  output logic                         up_above_out,
  input  logic                         lo_below_in,
  output logic                         lo_below_out,
  input  logic                         lo_le_in,
  output logic                         lo_le_out,
  input  logic signed [VALUE_BITS-1:0] up_rd_in,
  output logic signed [VALUE_BITS-1:0] up_rd_out,
  input  logic signed [VALUE_BITS-1:0] lo_rd_in,
  output logic signed [VALUE_BITS-1:0] lo_rd_out,
  input  logic signed [VALUE_BITS-1:0] ceil_in,
  output logic signed [VALUE_BITS-1:0] ceil_out,
  output logic signed [VALUE_BITS-1:0] up_q,
  output logic signed [VALUE_BITS-1:0] lo_q
);

  localparam logic signed [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] V_MAX = ~V_MIN;
  localparam logic                  HIT_OK = (POS < INDEX_SPAN);
  localparam logic [INDEX_BITS-1:0] POS_IDX = INDEX_BITS'(POS);

  logic in_use, is_last, up_gt, lo_lt, hit;
  logic signed [VALUE_BITS-1:0] up_next, lo_next;

  assign in_use  = NW'(POS) < used_n;
  assign is_last = NW'(POS) == (used_n - NW'(1));

  // bottom cell is the default landing place of the upper list
  assign up_gt = in_use && ((POS == 0) || (v > up_q));
  // last in-use cell is the default landing place of the lower list
  assign lo_lt = in_use && (is_last || (v < lo_q));

  assign up_above_out = up_gt | up_above_in;
  assign lo_below_out = lo_lt | lo_below_in;
  assign lo_le_out    = lo_le_in | (is_last && (v <= lo_q));

  assign hit       = HIT_OK && (rd_index == POS_IDX);
  assign up_rd_out = up_rd_in | (hit ? up_q : '0);
  assign lo_rd_out = lo_rd_in | (hit ? lo_q : '0);
  assign ceil_out  = ceil_in | (is_last ? lo_q : '0);

  always_comb begin
    up_next = up_q;
    lo_next = lo_q;
    if (ctl.offer && ctl.up_taken && in_use) begin
      if (up_above_in) begin
        up_next = up_nb;
      end else if (up_gt) begin
        up_next = v;
      end
    end
    if (ctl.offer && ctl.lo_taken && in_use) begin
      if (lo_below_in) begin
        lo_next = lo_nb;
      end else if (lo_lt) begin
        lo_next = v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      up_q <= V_MIN;
      lo_q <= V_MAX;
    end else begin
      up_q <= up_next;
      lo_q <= lo_next;
    end
  end

endmodule

[src/running_top_and_bottom_k_tracker.sv]
// ordering: at acceptance the cells update and the request goes to the pending register;
// its result is registered from there once the output register is empty or being taken
// throughput: one request per cycle while results are taken; the compare-and-shift
// over the cell chain finishes within the accepting cycle
// reset: synchronous; upper entries go to the most negative value, lower entries to
// the most positive value, kept_count to 64, both channels empty
module running_top_and_bottom_k_tracker import rtbk_pkg::*; #(
  parameter int unsigned MAX_KEPT   = DEF_MAX_KEPT,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  rtbk_req_if.sink    req,
  rtbk_res_if.source  res,
  rtbk_cfg_if.sink    cfg
);

  localparam int unsigned CB = $clog2(MAX_KEPT + 1);
  localparam int unsigned NW = (CB > COUNT_BITS) ? CB : COUNT_BITS;

  logic [COUNT_BITS-1:0] kept_count;
  logic [NW-1:0]         kc_ext, used_n;

  logic signed [VALUE_BITS-1:0] v;
  logic signed [VALUE_BITS-1:0] up_q [MAX_KEPT];
  logic signed [VALUE_BITS-1:0] lo_q [MAX_KEPT];
  logic                         up_above_c [MAX_KEPT+1];
  logic                         lo_below_c [MAX_KEPT+1];
  logic                         lo_le_c    [MAX_KEPT+1];
  logic signed [VALUE_BITS-1:0] up_rd_c    [MAX_KEPT+1];
  logic signed [VALUE_BITS-1:0] lo_rd_c    [MAX_KEPT+1];
  logic signed [VALUE_BITS-1:0] ceil_c     [MAX_KEPT+1];

  logic      accept, move, up_taken, lo_taken;
  cell_ctl_t ctl;

  logic                  pend_valid, pend_read, pend_ut, pend_lt;
  logic [INDEX_BITS-1:0] pend_index;

  logic                       out_valid, out_ut, out_lt;
  logic signed [OUT_BITS-1:0] out_upper, out_lower, out_floor, out_ceiling;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= KEPT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      kept_count <= cfg.data;
    end
  end

  assign kc_ext = NW'(kept_count);

  always_comb begin
    priority if (kc_ext == '0) begin
      used_n = NW'(1);
    end else if (kc_ext > NW'(MAX_KEPT)) begin
      used_n = NW'(MAX_KEPT);
    end else begin
      used_n = kc_ext;
    end
  end

  // request side
  assign move      = pend_valid && (!out_valid || res.ready);
  assign req.ready = !pend_valid || move;
  assign accept    = req.valid && req.ready;
  assign v         = VALUE_BITS'(req.value);

  assign up_taken  = v >= up_q[0];
  assign lo_taken  = lo_le_c[MAX_KEPT];

  assign ctl.offer    = accept && (req.req_type == REQ_OFFER);
  assign ctl.up_taken = up_taken;
  assign ctl.lo_taken = lo_taken;

  assign up_above_c[MAX_KEPT] = 1'b0;
  assign lo_below_c[0]        = 1'b0;
  assign lo_le_c[0]           = 1'b0;
  assign up_rd_c[0]           = '0;
  assign lo_rd_c[0]           = '0;
  assign ceil_c[0]            = '0;

  for (genvar j = 0; j < MAX_KEPT; j++) begin : g_cell
    logic signed [VALUE_BITS-1:0] up_nb, lo_nb;

    if (j + 1 < MAX_KEPT) begin : g_up_nb
      assign up_nb = up_q[j+1];
    end else begin : g_up_top
      assign up_nb = up_q[j];
    end
    if (j > 0) begin : g_lo_nb
      assign lo_nb = lo_q[j-1];
    end else begin : g_lo_bot
      assign lo_nb = lo_q[j];
    end

    rtbk_cell #(
      .POS        (j),
      .VALUE_BITS (VALUE_BITS),
      .NW         (NW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .v            (v),
      .used_n       (used_n),
      .rd_index     (pend_index),
      .up_nb        (up_nb),
      .lo_nb        (lo_nb),
      .up_above_in  (up_above_c[j+1]),
      .up_above_out (up_above_c[j]),
      .lo_below_in  (lo_below_c[j]),
      .lo_below_out (lo_below_c[j+1]),
      .lo_le_in     (lo_le_c[j]),
      .lo_le_out    (lo_le_c[j+1]),
      .up_rd_in     (up_rd_c[j]),
      .up_rd_out    (up_rd_c[j+1]),
      .lo_rd_in     (lo_rd_c[j]),
      .lo_rd_out    (lo_rd_c[j+1]),
      .ceil_in      (ceil_c[j]),
      .ceil_out     (ceil_c[j+1]),
      .up_q         (up_q[j]),
      .lo_q         (lo_q[j])
    );
  end

  // pending request: cells already hold its updated lists
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_read  <= (req.req_type == REQ_READ);
      pend_index <= req.index;
      pend_ut    <= (req.req_type == REQ_OFFER) && up_taken;
      pend_lt    <= (req.req_type == REQ_OFFER) && lo_taken;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_upper   <= pend_read ? OUT_BITS'(up_rd_c[MAX_KEPT]) : '0;
      out_lower   <= pend_read ? OUT_BITS'(lo_rd_c[MAX_KEPT]) : '0;
      out_ut      <= pend_ut;
      out_lt      <= pend_lt;
      out_floor   <= OUT_BITS'(up_q[0]);
      out_ceiling <= OUT_BITS'(ceil_c[MAX_KEPT]);
    end
  end

  assign res.valid         = out_valid;
  assign res.upper_entry   = out_upper;
  assign res.lower_entry   = out_lower;
  assign res.upper_taken   = out_ut;
  assign res.lower_taken   = out_lt;
  assign res.upper_floor   = out_floor;
  assign res.lower_ceiling = out_ceiling;

endmodule

[src/rtbk_checker.sv]
// port-level checks for the running top/bottom-k tracker
// bound to running_top_and_bottom_k_tracker; uses rtbk_pkg
module rtbk_checker import rtbk_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic signed [OUT_BITS-1:0] upper_entry,
  input logic signed [OUT_BITS-1:0] lower_entry,
  input logic                       upper_taken,
  input logic                       lower_taken
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(upper_entry) && $stable(lower_entry))
    else $error("result changed while stalled");

  // once an accepted request can have passed the pending and output registers, a result is valid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |-> ##2 res_valid)
    else $error("result missing after accepted request");

  // an offer result carries no list entries
  a_offer_entries: assert property (@(posedge clk) disable iff (rst)
    res_valid && (upper_taken || lower_taken) |-> upper_entry == '0 && lower_entry == '0)
    else $error("offer result with nonzero entries");

  // nothing pending right after reset
  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> req_ready && !res_valid)
    else $error("not empty after reset");

endmodule

bind running_top_and_bottom_k_tracker rtbk_checker u_rtbk_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .upper_entry (res.upper_entry),
  .lower_entry (res.lower_entry),
  .upper_taken (res.upper_taken),
  .lower_taken (res.lower_taken)
);
